// ----- rtl/esort_pkg.sv -----
`default_nettype none
package esort_pkg;

  localparam int unsigned ScoreW = 32;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned RankW  = 5;
  localparam int unsigned CntW   = 7;
  localparam int unsigned CfgW   = 6;

  // One sorted entry: score and its arrival index.
  typedef struct packed {
    logic signed [ScoreW-1:0] score;
    logic [IdxW-1:0]          index;
  } entry_t;

  // Handoff from cell i to cell i+1.
  typedef struct packed {
    logic   gt;     // this cell holds a score greater than the new one
    entry_t entry;
  } link_t;

  // Broadcast control shared by every cell.
  typedef struct packed {
    logic            insert;
    logic            shift;
    logic [CntW-1:0] fill;
    entry_t          din;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/elitist_survivor_sort.sv -----
`default_nettype none
// Survivor selection for one generation. Load 2N signed Q16.16 scores, one per
// accepted request (start_i high while busy_o is low): parents first, then
// offspring. Each score drops into place in a row of 2*MAX_POPULATION sort
// cells in the cycle it arrives, so loading runs at one score per clock. The
// request that brings score 2N raises busy_o on the next cycle; the row then
// shifts out toward cell 0 and the N best arrival indices come out back to
// back, each held for exactly one cycle with result_valid_o high, lowest score
// first, ties by lower arrival index, last_flag_o on the
// final one. There is no back-pressure: the receiver must take every result.
// busy_o drops after the last result. Write population_size only while idle: a
// write discards any partial run. Sizes of 0 act as 1, sizes above
// MAX_POPULATION act as it.
module elitist_survivor_sort #(
  parameter int unsigned MAX_POPULATION = 32
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            population_size_we_i,
  input  wire  [esort_pkg::CfgW-1:0]     population_size_i,
  input  wire                            start_i,
  input  wire  signed [esort_pkg::ScoreW-1:0] score_i,
  output logic                           busy_o,
  output logic                           result_valid_o,
  output logic [esort_pkg::IdxW-1:0]     source_index_o,
  output logic [esort_pkg::RankW-1:0]    rank_o,
  output logic                           last_flag_o
);

  localparam int unsigned Depth = 2 * MAX_POPULATION;

  logic [esort_pkg::CfgW-1:0]  pop_q;
  logic [esort_pkg::CntW-1:0]  load_count_q, load_count_d;
  logic                        drain_q, drain_d;
  logic [esort_pkg::RankW-1:0] rank_q, rank_d;

  logic [esort_pkg::CfgW-1:0]  n_eff;
  logic [esort_pkg::CntW-1:0]  total;
  logic [esort_pkg::RankW-1:0] last_rank;
  logic                        accept;
  logic                        is_last;

  esort_pkg::cell_ctrl_t ctrl;
  esort_pkg::link_t      links [Depth];

  // Clamp the size register to 1..MAX_POPULATION.
  always_comb begin
    n_eff = pop_q;
    if (pop_q == '0) begin
      n_eff = esort_pkg::CfgW'(1);
    end else if (pop_q > esort_pkg::CfgW'(MAX_POPULATION)) begin
      n_eff = esort_pkg::CfgW'(MAX_POPULATION);
    end
  end

  assign total     = {1'b0, n_eff} << 1;
  assign last_rank = esort_pkg::RankW'(n_eff - esort_pkg::CfgW'(1));
  assign accept    = start_i && !drain_q;
  assign is_last   = rank_q == last_rank;

  // Broadcast to the cells: new entry tagged with its arrival index.
  always_comb begin
    ctrl.insert       = accept;
    ctrl.shift        = drain_q;
    ctrl.fill         = load_count_q;
    ctrl.din.score    = score_i;
    ctrl.din.index    = load_count_q[esort_pkg::IdxW-1:0];
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    esort_pkg::link_t  prev;
    esort_pkg::entry_t next;
    if (i == 0) begin : g_head
      assign prev.gt    = 1'b0;
      assign prev.entry = links[i].entry;
    end else begin : g_body
      assign prev = links[i-1];
    end
    if (i == Depth - 1) begin : g_tail
      assign next = links[i].entry;
    end else begin : g_mid
      assign next = links[i+1].entry;
    end
    esort_cell #(
      .INDEX(i)
    ) u_cell (
      .clk_i (clk_i),
      .ctrl_i(ctrl),
      .prev_i(prev),
      .next_i(next),
      .link_o(links[i])
    );
  end

  // Run control: count loads, then drain N results.
  always_comb begin
    load_count_d = load_count_q;
    drain_d      = drain_q;
    rank_d       = rank_q;
    if (population_size_we_i) begin
      load_count_d = '0;
    end else if (accept) begin
      if (load_count_q + esort_pkg::CntW'(1) == total) begin
        load_count_d = '0;
        drain_d      = 1'b1;
        rank_d       = '0;
      end else begin
        load_count_d = load_count_q + esort_pkg::CntW'(1);
      end
    end else if (drain_q) begin
      rank_d = rank_q + esort_pkg::RankW'(1);
      if (is_last) begin
        drain_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_q        <= esort_pkg::CfgW'(32);
      load_count_q <= '0;
      drain_q      <= 1'b0;
      rank_q       <= '0;
    end else begin
      if (population_size_we_i) begin
        pop_q <= population_size_i;
      end
      load_count_q <= load_count_d;
      drain_q      <= drain_d;
      rank_q       <= rank_d;
    end
  end

  // Cell 0 always holds the next survivor while draining.
  assign busy_o         = drain_q;
  assign result_valid_o = drain_q;
  assign source_index_o = links[0].entry.index;
  assign rank_o         = rank_q;
  assign last_flag_o    = drain_q && is_last;

  a_count_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_count_q < total)
    else $error("load count past run length");

  a_drain_after_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(drain_q) |-> $past(start_i) && !$past(drain_q))
    else $error("drain started without a final load");

  a_rank_steps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_flag_o |=>
      result_valid_o && rank_o == $past(rank_o) + esort_pkg::RankW'(1))
    else $error("result ranks not consecutive");

  a_last_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_flag_o |=> !result_valid_o && load_count_q == '0)
    else $error("results continue after last");

endmodule
`default_nettype wire

// ----- rtl/esort_cell.sv -----
`default_nettype none
module esort_cell #(
  parameter int unsigned INDEX = 0
) (
  input  wire                   clk_i,
  input  esort_pkg::cell_ctrl_t ctrl_i,
  input  esort_pkg::link_t      prev_i,
  input  esort_pkg::entry_t     next_i,
  output esort_pkg::link_t      link_o
);

  esort_pkg::entry_t entry_q, entry_d;
  logic occupied, is_tail, gt;

  assign occupied = ctrl_i.fill > esort_pkg::CntW'(INDEX);
  assign is_tail  = ctrl_i.fill == esort_pkg::CntW'(INDEX);
  // strict compare keeps equal scores in arrival order
  assign gt       = occupied && (entry_q.score > ctrl_i.din.score);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      if (prev_i.gt) begin
        entry_d = prev_i.entry;
      end else if (gt || is_tail) begin
        entry_d = ctrl_i.din;
      end
    end else if (ctrl_i.shift) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign link_o.gt    = gt;
  assign link_o.entry = entry_q;

endmodule
`default_nettype wire
